// ===== src/lia_pkg.sv =====
`timescale 1ns / 1ps
package lia_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 32;
    localparam int RATE_W      = 19;
    localparam int ACC_W       = 32;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_RATE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_OUTPUTS = 3'd5;

    localparam logic [1:0] WIDTH_BYTE  = 2'd1;
    localparam logic [1:0] CHAN_STEREO = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic check;
        logic mul;
        logic add;
        logic push;
        logic fin;
        logic last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;
        logic out_free;
    } t_status;

endpackage

// ===== src/lia_in_if.sv =====
`timescale 1ns / 1ps
interface lia_in_if
    import lia_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] left_raw;
    logic [SAMPLE_BITS-1:0] right_raw;
    logic                   is_last;

    modport source (output valid, output left_raw, output right_raw, output is_last,
                    input ready);
    modport sink   (input valid, input left_raw, input right_raw, input is_last,
                    output ready);
endinterface

// ===== src/lia_out_if.sv =====
`timescale 1ns / 1ps
interface lia_out_if
    import lia_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          last_of_run;
    logic                          sound_done;

    modport source (output valid, output left_out, output right_out,
                    output last_of_run, output sound_done, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input last_of_run, input sound_done, output ready);
endinterface

// ===== src/lia_ctrl.sv =====
`timescale 1ns / 1ps
module lia_ctrl
    import lia_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_PUSH,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_pend;   // a computed result waits for its last_of_run decision
    logic   r_more;   // another result follows the pending one

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_more <= i_status.more;
                    if (r_pend) begin
                        r_state <= S_PUSH;
                    end else if (i_status.more) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_pend  <= 1'b1;
                    r_state <= S_CHECK;
                end
                S_PUSH: begin
                    if (i_status.out_free) begin
                        r_pend  <= 1'b0;
                        r_state <= r_more ? S_MUL : S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cmd.start = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.check = (r_state == S_CHECK);
    assign o_cmd.mul   = (r_state == S_MUL);
    assign o_cmd.add   = (r_state == S_ADD);
    assign o_cmd.push  = (r_state == S_PUSH);
    assign o_cmd.fin   = (r_state == S_FIN);
    assign o_cmd.last  = !r_more;

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("result left pending at end of item");

    a_push_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> r_pend)
        else $error("push without a computed result");

    a_add_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |=> (r_state == S_CHECK) && r_pend)
        else $error("add step did not return to check");

endmodule

// ===== src/lia_datapath.sv =====
`timescale 1ns / 1ps
module lia_datapath
    import lia_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]        i_left_raw,
    input  logic [SAMPLE_BITS-1:0]        i_right_raw,
    input  logic                          i_is_last,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    output logic                          o_last_of_run,
    output logic                          o_sound_done
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    // Configuration registers.
    logic [1:0]        r_swidth;
    logic [1:0]        r_chans;
    logic [RATE_W-1:0] r_in_rate;
    logic [RATE_W-1:0] r_out_rate;
    logic [ACC_W-1:0]  r_step;
    logic [ACC_W-1:0]  r_total;

    // Sound state.
    logic signed [SAMPLE_BITS-1:0] r_prev_l;
    logic signed [SAMPLE_BITS-1:0] r_prev_r;
    logic                          r_have_prev;
    logic [ACC_W-1:0]              r_acc;
    logic [RATE_W-1:0]             r_ois;
    logic [ACC_W-1:0]              r_base;
    logic [ACC_W-1:0]              r_idx;
    logic [ACC_W-1:0]              r_emitted;

    // Current item.
    logic signed [SAMPLE_BITS-1:0] r_cur_l;
    logic signed [SAMPLE_BITS-1:0] r_cur_r;
    logic                          r_last;
    logic [CNT_W-1:0]              r_count;
    logic                          r_phase;   // still in the interpolation pass
    logic                          r_mode;    // the result being built is interpolated

    // Arithmetic pipeline and output register.
    logic signed [PROD_W-1:0]      r_prod_l;
    logic signed [PROD_W-1:0]      r_prod_r;
    logic signed [SAMPLE_BITS-1:0] r_res_l;
    logic signed [SAMPLE_BITS-1:0] r_res_r;
    logic                          r_res_done;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;
    logic                          r_out_last;
    logic                          r_out_done;

    logic                          stereo;
    logic                          base_ok;
    logic [ACC_W:0]                pint;
    logic                          use_interp;
    logic                          out_free;
    logic signed [SAMPLE_BITS-1:0] prev_r_eff;
    logic signed [DIFF_W-1:0]      diff_l;
    logic signed [DIFF_W-1:0]      diff_r;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PROD_W-1:0]      q_l;
    logic signed [PROD_W-1:0]      q_r;
    logic signed [DIFF_W-1:0]      sum_l;
    logic signed [DIFF_W-1:0]      sum_r;
    logic [ACC_W-1:0]              n_acc;
    logic [RATE_W-1:0]             n_ois;
    logic [ACC_W-1:0]              n_emitted;

    // 8-bit samples are offset binary: flipping the top bit recenters them.
    function automatic logic signed [SAMPLE_BITS-1:0] decode(
        input logic [1:0]             swidth,
        input logic [SAMPLE_BITS-1:0] raw
    );
        logic signed [SAMPLE_BITS-1:0] v;
        begin
            if (swidth == WIDTH_BYTE) begin
                v = {{(SAMPLE_BITS-7){~raw[7]}}, raw[6:0]};
            end else begin
                v = raw;
            end
            return v;
        end
    endfunction

    assign stereo     = (r_chans == CHAN_STEREO);
    assign base_ok    = (r_count < CNT_W'(MAX_RESULTS)) && (r_emitted < r_total);
    assign pint       = {1'b0, r_base} + {{(FRAC_BITS+1){1'b0}}, r_acc[ACC_W-1:FRAC_BITS]};
    assign use_interp = r_phase && r_have_prev && (pint < {1'b0, r_idx});
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_status.more     = base_ok && (use_interp || r_last);
    assign o_status.out_free = out_free;

    assign prev_r_eff = stereo ? r_prev_r : '0;
    assign diff_l     = DIFF_W'(r_cur_l) - DIFF_W'(r_prev_l);
    assign diff_r     = DIFF_W'(r_cur_r) - DIFF_W'(prev_r_eff);
    assign frac_s     = {1'b0, r_acc[FRAC_BITS-1:0]};

    // Arithmetic shift gives the floor of the scaled difference.
    assign q_l   = r_prod_l >>> FRAC_BITS;
    assign q_r   = r_prod_r >>> FRAC_BITS;
    assign sum_l = DIFF_W'(r_prev_l) + q_l[DIFF_W-1:0];
    assign sum_r = DIFF_W'(prev_r_eff) + q_r[DIFF_W-1:0];

    assign n_acc     = r_acc + r_step;
    assign n_ois     = r_ois + RATE_W'(1);
    assign n_emitted = r_emitted + ACC_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swidth    <= 2'd2;
            r_chans     <= 2'd1;
            r_in_rate   <= RATE_W'(48000);
            r_out_rate  <= RATE_W'(48000);
            r_step      <= ACC_W'(16384);
            r_total     <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_have_prev <= 1'b0;
            r_acc       <= '0;
            r_ois       <= '0;
            r_base      <= '0;
            r_idx       <= '0;
            r_emitted   <= '0;
            r_last      <= 1'b0;
            r_count     <= '0;
            r_phase     <= 1'b0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_WIDTH:  r_swidth   <= i_cfg_wdata[1:0];
                    CFG_CHANNEL_COUNT: r_chans    <= i_cfg_wdata[1:0];
                    CFG_IN_RATE:       r_in_rate  <= i_cfg_wdata[RATE_W-1:0];
                    CFG_OUT_RATE:      r_out_rate <= i_cfg_wdata[RATE_W-1:0];
                    CFG_POSITION_STEP: r_step     <= i_cfg_wdata[ACC_W-1:0];
                    CFG_TOTAL_OUTPUTS: r_total    <= i_cfg_wdata[ACC_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.start) begin
                r_last  <= i_is_last;
                r_count <= '0;
                r_phase <= 1'b1;
            end

            if (i_cmd.check) begin
                r_mode <= use_interp;
                if (!use_interp) begin
                    r_phase <= 1'b0;
                end
            end

            if (i_cmd.add) begin
                r_count   <= r_count + CNT_W'(1);
                r_emitted <= n_emitted;
                if (n_ois == r_out_rate) begin
                    r_ois  <= '0;
                    r_acc  <= '0;
                    r_base <= r_base + ACC_W'(r_in_rate);
                end else begin
                    r_ois <= n_ois;
                    r_acc <= n_acc;
                end
            end

            if (i_cmd.fin) begin
                if (r_last) begin
                    r_prev_l    <= '0;
                    r_prev_r    <= '0;
                    r_have_prev <= 1'b0;
                    r_acc       <= '0;
                    r_ois       <= '0;
                    r_base      <= '0;
                    r_idx       <= '0;
                    r_emitted   <= '0;
                end else begin
                    r_prev_l    <= r_cur_l;
                    r_prev_r    <= r_cur_r;
                    r_have_prev <= 1'b1;
                    r_idx       <= r_idx + ACC_W'(1);
                end
            end

            if (i_cmd.push && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cur_l <= decode(r_swidth, i_left_raw);
            r_cur_r <= stereo ? decode(r_swidth, i_right_raw) : '0;
        end
        if (i_cmd.mul) begin
            r_prod_l <= diff_l * frac_s;
            r_prod_r <= diff_r * frac_s;
        end
        if (i_cmd.add) begin
            r_res_done <= (n_emitted == r_total);
            if (r_mode) begin
                r_res_l <= sum_l[SAMPLE_BITS-1:0];
                r_res_r <= sum_r[SAMPLE_BITS-1:0];
            end else begin
                r_res_l <= r_cur_l;
                r_res_r <= r_cur_r;
            end
        end
        if (i_cmd.push && out_free) begin
            r_out_l    <= r_res_l;
            r_out_r    <= r_res_r;
            r_out_last <= i_cmd.last;
            r_out_done <= r_res_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_out    = r_out_l;
    assign o_right_out   = r_out_r;
    assign o_last_of_run = r_out_last;
    assign o_sound_done  = r_out_done;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RESULTS))
        else $error("result count above cap");

    a_push_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && out_free) |=> r_out_valid)
        else $error("output register not loaded on push");

    a_tail_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_phase && !i_cmd.start) |=> !r_phase)
        else $error("interpolation pass resumed after tail copies began");

endmodule

// ===== src/linear_interp_audio_resampler.sv =====
`timescale 1ns / 1ps
// Channel      Dir   Fields                                            Transfer
// i_in_ch      in    left_raw[15:0] right_raw[15:0] is_last            valid & ready
// o_out_ch     out   left_out[15:0] right_out[15:0] last_of_run        valid & ready
//                    sound_done
// i_cfg_*      in    i_cfg_idx[2:0] i_cfg_wdata[31:0]                  i_cfg_we
//
// An input frame that makes no result is taken, position-checked and finished; each result adds
// a multiply, an add, a position check and a hand-off step, in that order.
// Reset is synchronous and active low; it restores the register defaults and clears the sound.
// A result waits in the output register while the next input frame is taken;
// a stalled output holds the datapath in its hand-off step.
module linear_interp_audio_resampler
    import lia_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    lia_in_if.sink               i_in_ch,
    lia_out_if.source            o_out_ch
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    lia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lia_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_left_raw    (i_in_ch.left_raw),
        .i_right_raw   (i_in_ch.right_raw),
        .i_is_last     (i_in_ch.is_last),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (o_out_ch.ready),
        .o_out_valid   (o_out_ch.valid),
        .o_left_out    (o_out_ch.left_out),
        .o_right_out   (o_out_ch.right_out),
        .o_last_of_run (o_out_ch.last_of_run),
        .o_sound_done  (o_out_ch.sound_done)
    );

    assign i_in_ch.ready = in_ready;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import lia_pkg::*;

    localparam int     FRAC           = 14;
    localparam int     RANDOM_FRAMES  = 425;
    localparam int     SETTLE_CYCLES  = 32;
    localparam int     DRAIN_CYCLES   = 300;
    localparam longint CYCLE_LIMIT    = 12000000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_raw;
        logic [SAMPLE_BITS-1:0] right_raw;
        logic                   is_last;
    } raw_frame_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          last_of_run;
        logic                          sound_done;
    } out_frame_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    lia_in_if  in_ch ();
    lia_out_if out_ch ();

    linear_interp_audio_resampler #(
        .FRAC_BITS (FRAC)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // Register copy, starting from the values the block resets to.
    logic [1:0]        width_cfg    = 2'd2;
    logic [1:0]        chan_cfg     = 2'd1;
    logic [RATE_W-1:0] in_rate_cfg  = 19'd48000;
    logic [RATE_W-1:0] out_rate_cfg = 19'd48000;
    logic [ACC_W-1:0]  step_cfg     = 32'd16384;
    logic [31:0]       total_cfg    = 32'd0;

    // Per-sound resampler state.
    logic signed [SAMPLE_BITS-1:0] prev_l      = '0;
    logic signed [SAMPLE_BITS-1:0] prev_r      = '0;
    logic                          have_prev   = 1'b0;
    logic [ACC_W-1:0]              pos_acc     = '0;
    logic [RATE_W-1:0]             outs_in_sec = '0;
    logic [31:0]                   sec_base    = '0;
    logic [31:0]                   frame_idx   = '0;
    logic [31:0]                   emitted     = '0;

    raw_frame_t frames_to_send[$];
    out_frame_t resampled_q[$];

    bit     frame_taken   = 1'b0;
    bit     in_gaps_on    = 1'b1;
    bit     out_stalls_on = 1'b1;
    int     in_gap        = 0;
    int     out_stall     = 0;
    int     mismatches    = 0;
    int     frames_queued = 0;
    int     frames_taken  = 0;
    int     sounds_ended  = 0;
    int     results_seen  = 0;
    int     configs_set   = 0;
    longint cycle_count   = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] decode_sample(input logic [15:0] raw);
        int v;
        if (width_cfg == WIDTH_BYTE) v = int'(raw[7:0]) - 128;
        else v = int'($signed(raw));
        return v[15:0];
    endfunction

    // a + floor((b - a) * frac / 2^FRAC); the arithmetic shift gives the floor.
    function automatic logic signed [SAMPLE_BITS-1:0] lerp(input logic signed [15:0] a,
                                                           input logic signed [15:0] b,
                                                           input logic [FRAC-1:0] frac);
        longint d;
        longint s;
        d = (longint'(b) - longint'(a)) * longint'(frac);
        s = longint'(a) + (d >>> FRAC);
        return s[15:0];
    endfunction

    task automatic advance_output(input logic signed [15:0] l, input logic signed [15:0] r,
                                  output out_frame_t o);
        pos_acc     = pos_acc + step_cfg;
        outs_in_sec = outs_in_sec + 19'd1;
        if (outs_in_sec == out_rate_cfg) begin
            outs_in_sec = '0;
            pos_acc     = '0;
            sec_base    = sec_base + 32'(in_rate_cfg);
        end
        emitted       = emitted + 32'd1;
        o.left        = l;
        o.right       = r;
        o.last_of_run = 1'b0;
        o.sound_done  = (emitted == total_cfg);
    endtask

    task automatic resample_step(input logic [15:0] lraw, input logic [15:0] rraw,
                                 input logic last);
        logic                          stereo;
        logic                          caught_up;
        logic signed [SAMPLE_BITS-1:0] cl, cr, pl, pr;
        logic [FRAC-1:0]               frac;
        out_frame_t                    o;
        out_frame_t                    held;
        int                            n;
        stereo    = (chan_cfg == CHAN_STEREO);
        cl        = decode_sample(lraw);
        cr        = stereo ? decode_sample(rraw) : '0;
        pl        = prev_l;
        pr        = stereo ? prev_r : '0;
        n         = 0;
        caught_up = !have_prev;
        while (!caught_up && n < MAX_RESULTS && emitted < total_cfg) begin
            if (64'(sec_base) + 64'(pos_acc >> FRAC) >= 64'(frame_idx)) begin
                caught_up = 1'b1;
            end else begin
                frac = pos_acc[FRAC-1:0];
                advance_output(lerp(pl, cl, frac), stereo ? lerp(pr, cr, frac) : '0, o);
                if (n > 0) resampled_q.push_back(held);
                held = o;
                n++;
            end
        end
        // The final frame pads the sound out to its length with copies of itself, up to the per-frame result cap.
        while (last && n < MAX_RESULTS && emitted < total_cfg) begin
            advance_output(cl, cr, o);
            if (n > 0) resampled_q.push_back(held);
            held = o;
            n++;
        end
        if (n > 0) begin
            held.last_of_run = 1'b1;
            resampled_q.push_back(held);
        end
        if (last) begin
            prev_l      = '0;
            prev_r      = '0;
            have_prev   = 1'b0;
            pos_acc     = '0;
            outs_in_sec = '0;
            sec_base    = '0;
            frame_idx   = '0;
            emitted     = '0;
            sounds_ended++;
        end else begin
            prev_l    = cl;
            prev_r    = cr;
            have_prev = 1'b1;
            frame_idx = frame_idx + 32'd1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("ERROR at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SAMPLE_WIDTH:  width_cfg    = value[1:0];
            CFG_CHANNEL_COUNT: chan_cfg     = value[1:0];
            CFG_IN_RATE:       in_rate_cfg  = value[RATE_W-1:0];
            CFG_OUT_RATE:      out_rate_cfg = value[RATE_W-1:0];
            CFG_POSITION_STEP: step_cfg     = value;
            CFG_TOTAL_OUTPUTS: total_cfg    = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] w, input logic [1:0] c,
                              input logic [RATE_W-1:0] inr, input logic [RATE_W-1:0] outr,
                              input logic [31:0] step, input logic [31:0] total);
        write_reg(CFG_SAMPLE_WIDTH, 32'(w));
        write_reg(CFG_CHANNEL_COUNT, 32'(c));
        write_reg(CFG_IN_RATE, 32'(inr));
        write_reg(CFG_OUT_RATE, 32'(outr));
        write_reg(CFG_POSITION_STEP, step);
        write_reg(CFG_TOTAL_OUTPUTS, total);
        configs_set++;
    endtask

    task automatic queue_frame(input logic [15:0] l, input logic [15:0] r, input logic last);
        raw_frame_t f;
        f.left_raw  = l;
        f.right_raw = r;
        f.is_last   = last;
        frames_to_send.push_back(f);
        frames_queued++;
    endtask

    task automatic wait_until_drained(input int settle);
        while (frames_to_send.size() != 0 || in_ch.valid || resampled_q.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        logic [15:0] corner[7] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                                   16'h0080, 16'h007F, 16'h00FF};
        if ($urandom_range(0, 6) == 0) return corner[$urandom_range(0, 6)];
        return 16'($urandom);
    endfunction

    task automatic random_phase();
        int          audio_rates[6] = '{8000, 11025, 22050, 44100, 48000, 96000};
        logic [1:0]  w, c;
        logic [18:0] inr, outr;
        longint      ratio;
        longint      est;
        longint      t;
        int          pick;
        int          len;
        int          sounds;
        bit          broken;
        pick = $urandom_range(0, 9);
        w = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd3 : (pick < 6) ? WIDTH_BYTE : 2'd2;
        pick = $urandom_range(0, 9);
        c = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd3 : (pick < 6) ? CHAN_STEREO : 2'd1;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            inr  = 19'($urandom_range(1, 6));
            outr = 19'($urandom_range(1, 6));
        end else if (pick < 9) begin
            inr  = 19'(audio_rates[$urandom_range(0, 5)]);
            outr = 19'(audio_rates[$urandom_range(0, 5)]);
        end else begin
            inr  = $urandom_range(0, 1) ? 19'd262144 : 19'd0;
            outr = $urandom_range(0, 1) ? 19'd262144 : 19'd0;
        end
        // A zero output rate only restarts after 2^19 outputs.
        if (outr == 0) ratio = (longint'(inr) << FRAC) / 524288;
        else ratio = (longint'(inr) << FRAC) / longint'(outr);
        // Now and then the step disagrees with the rates, so restarts land behind.
        pick = $urandom_range(0, 4);
        if (pick == 0) ratio = ratio * 2;
        else if (pick == 1) ratio = ratio + longint'($urandom_range(0, 1000)) - 500;
        if (ratio < 512) ratio = 512;
        if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        est = (longint'(len - 1) * 16384) / ratio;
        pick = $urandom_range(0, 9);
        if (pick == 0) t = 0;
        else if (pick == 1) t = 64'hFFFF_FFFF;
        else t = est + longint'($urandom_range(0, 12)) - 4;
        if (t < 0) t = 0;
        set_config(w, c, inr, outr, ratio[31:0], t[31:0]);
        sounds = $urandom_range(1, 3);
        for (int s = 0; s < sounds; s++) begin
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                queue_frame(pick_sample(), pick_sample(),
                            broken ? ($urandom_range(0, 15) == 0) : (i == len - 1));
            end
        end
    endtask

    always @(posedge i_clk) begin
        frame_taken = in_ch.valid && in_ch.ready;
        if (frame_taken) begin
            resample_step(in_ch.left_raw, in_ch.right_raw, in_ch.is_last);
            frames_taken++;
        end
    end

    always @(negedge i_clk) begin : drive_frames
        raw_frame_t f;
        if (i_rst_n && (!in_ch.valid || frame_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (frames_to_send.size() != 0) begin
                f = frames_to_send.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.left_raw  <= f.left_raw;
                in_ch.right_raw <= f.right_raw;
                in_ch.is_last   <= f.is_last;
                in_gap = in_gaps_on ? idle_len() : 0;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (out_stalls_on && $urandom_range(0, 4) == 0) out_stall = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        out_frame_t want;
        if (out_ch.valid && out_ch.ready) begin
            if (resampled_q.size() == 0) begin
                report_mismatch("result with nothing pending, left_out", out_ch.left_out, 0);
            end else begin
                want = resampled_q.pop_front();
                results_seen++;
                if (out_ch.left_out !== want.left)
                    report_mismatch("left_out", out_ch.left_out, want.left);
                if (out_ch.right_out !== want.right)
                    report_mismatch("right_out", out_ch.right_out, want.right);
                if (out_ch.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", out_ch.last_of_run, want.last_of_run);
                if (out_ch.sound_done !== want.sound_done)
                    report_mismatch("sound_done", out_ch.sound_done, want.sound_done);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d results still pending.", resampled_q.size());
            $display("linear_interp_audio_resampler: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int directed_frames;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_SAMPLE_WIDTH;
        i_cfg_wdata     = '0;
        in_ch.valid     = 1'b0;
        in_ch.left_raw  = '0;
        in_ch.right_raw = '0;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Straight copy at 16-bit mono; the count runs out before the final frame.
        set_config(2'd2, 2'd1, 19'd48000, 19'd48000, 32'd16384, 32'd4);
        queue_frame(16'h8000, 16'h1357, 1'b0);
        queue_frame(16'h7FFF, 16'hFFFF, 1'b0);
        queue_frame(16'h0000, 16'h8000, 1'b0);
        queue_frame(16'hFFFF, 16'h7FFF, 1'b0);
        queue_frame(16'h1234, 16'h0000, 1'b0);
        queue_frame(16'hEDCB, 16'h2468, 1'b0);
        queue_frame(16'h4321, 16'hAAAA, 1'b1);
        wait_until_drained(SETTLE_CYCLES);

        // 8-bit stereo at three times the rate, then a padded tail.
        set_config(WIDTH_BYTE, CHAN_STEREO, 19'd1, 19'd3, 32'd5461, 32'd12);
        queue_frame(16'hFF00, 16'h00FF, 1'b0);
        queue_frame(16'h0080, 16'hFF7F, 1'b0);
        queue_frame(16'h1200, 16'h3480, 1'b0);
        queue_frame(16'hABFF, 16'h0001, 1'b1);
        wait_until_drained(SETTLE_CYCLES);

        // A lone final frame, then a step that overshoots so restarts fall behind.
        set_config(2'd2, CHAN_STEREO, 19'd1, 19'd2, 32'd49152, 32'd5);
        queue_frame(16'h7FFF, 16'h8000, 1'b1);
        queue_frame(16'h0100, 16'hFF00, 1'b0);
        queue_frame(16'h8000, 16'h7FFF, 1'b0);
        queue_frame(16'h3000, 16'hD000, 1'b0);
        queue_frame(16'hC000, 16'h4000, 1'b1);
        wait_until_drained(SETTLE_CYCLES);

        // A zero step never advances, so every frame after the first hits the per-frame result cap.
        set_config(2'd3, 2'd3, 19'd0, 19'd0, 32'd0, 32'd200);
        queue_frame(16'h8000, 16'h0000, 1'b0);
        queue_frame(16'h7FFF, 16'h0000, 1'b0);
        queue_frame(16'hFFFF, 16'h0000, 1'b0);
        queue_frame(16'h0001, 16'h0000, 1'b1);
        wait_until_drained(SETTLE_CYCLES);

        // Rates of 2^18, the largest step and length: the tail overflows the cap and is cut.
        set_config(2'd0, CHAN_STEREO, 19'd262144, 19'd262144, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_frame(16'h5A5A, 16'hA5A5, 1'b0);
        queue_frame(16'hA5A5, 16'h5A5A, 1'b0);
        queue_frame(16'h8001, 16'h7FFE, 1'b1);
        directed_frames = frames_queued;

        while (frames_queued < directed_frames + RANDOM_FRAMES) begin
            wait_until_drained(SETTLE_CYCLES);
            in_gaps_on    = ($urandom_range(0, 3) != 0);
            out_stalls_on = ($urandom_range(0, 3) != 0);
            random_phase();
        end

        wait_until_drained(DRAIN_CYCLES);
        $display("Covered %0d input frames, %0d ended sounds, %0d register settings.",
                 frames_taken, sounds_ended, configs_set);
        $display("Checked %0d resampled frames; %0d field errors.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("linear_interp_audio_resampler: match");
        end else begin
            $display("linear_interp_audio_resampler: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/lia_pkg.sv
src/lia_in_if.sv
src/lia_out_if.sv
src/lia_ctrl.sv
src/lia_datapath.sv
src/linear_interp_audio_resampler.sv
tb/sv/tb_top.sv
